[hw/rtl/fsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed slot pool package
// Shared types and constants for the fixed slot pool allocator.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int ADDR_W  = 32;
  localparam int BYTES_W = 17;
  localparam int CNT_W   = 9;
  localparam int CODE_W  = 2;
  localparam int CIDX_W  = 2;

  localparam logic [BYTES_W-1:0] MIN_SLOT_BYTES = BYTES_W'(8);

  // Register indexes of the configuration port.
  localparam logic [CIDX_W-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SLOT_BYTES = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SLOT_COUNT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [ADDR_W-1:0]  RST_POOL_BASE  = 32'd0;
  localparam logic [BYTES_W-1:0] RST_SLOT_BYTES = 17'd8;
  localparam logic [CNT_W-1:0]   RST_SLOT_COUNT = 9'd256;

  // Operation codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Outcome codes.
  localparam logic [CODE_W-1:0] OC_POOL     = 2'd0;
  localparam logic [CODE_W-1:0] OC_HEAP     = 2'd1;
  localparam logic [CODE_W-1:0] OC_NULL     = 2'd2;
  localparam logic [CODE_W-1:0] OC_OVERFLOW = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

[hw/rtl/fsp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed slot pool RAM
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module fsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/fixed_slot_pool_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed slot pool allocator
// Hands out and takes back equal-sized slots of a pool; freed addresses are
// kept on a stack held in a RAM.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       input      in_valid / in_stall   in_func, in_req_bytes, in_addr_in
//  out      output     out_valid / out_stall out_addr_out, out_outcome
//  cfg      input      cfg_we                cfg_index, cfg_data
//
// Each beat has an accept cycle, in which the RAM reads the stack top, and an
// execute cycle, which updates the pool state and loads the result register.
// A new beat is taken in the cycle after execute while the result waits.
// Reset restores the register defaults and empties the stack; the stack RAM
// is not cleared. A stalled result holds the block in execute until it drains.
// ----------------------------------------------------------------------------
module fixed_slot_pool_allocator #(
  parameter int POOL_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [fsp_pkg::BYTES_W-1:0]    in_req_bytes,
  input  logic [fsp_pkg::ADDR_W-1:0]     in_addr_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fsp_pkg::ADDR_W-1:0]     out_addr_out,
  output logic [fsp_pkg::CODE_W-1:0]     out_outcome,
  input  logic                           cfg_we,
  input  logic [fsp_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [fsp_pkg::ADDR_W-1:0]     cfg_data
);

  localparam int FILL_W  = $clog2(POOL_DEPTH + 1);
  localparam int AW      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CAP     = (POOL_DEPTH < 511) ? POOL_DEPTH : 511;
  localparam int PROD_W  = fsp_pkg::CNT_W + fsp_pkg::BYTES_W;
  localparam logic [FILL_W-1:0]          DEPTH_V = FILL_W'(POOL_DEPTH);
  localparam logic [fsp_pkg::CNT_W-1:0]  CAP_V   = fsp_pkg::CNT_W'(CAP);
  localparam logic [fsp_pkg::CNT_W-1:0]  RST_EFF_COUNT =
    (fsp_pkg::RST_SLOT_COUNT > CAP_V) ? CAP_V : fsp_pkg::RST_SLOT_COUNT;

  // Configuration registers.
  logic [fsp_pkg::ADDR_W-1:0]  pool_base_r;
  logic [fsp_pkg::BYTES_W-1:0] slot_bytes_r;
  logic [fsp_pkg::CNT_W-1:0]   slot_count_r;

  // Pool state.
  logic [fsp_pkg::CNT_W-1:0]   fresh_left_r, fresh_left_nxt;
  logic [FILL_W-1:0]           stack_fill_r, stack_fill_nxt;

  // Captured beat.
  logic                        func_r;
  logic [fsp_pkg::BYTES_W-1:0] req_r;
  logic [fsp_pkg::ADDR_W-1:0]  addr_r;

  // Result register.
  logic                        out_valid_r, out_valid_nxt;
  logic [fsp_pkg::ADDR_W-1:0]  addr_out_r, addr_out_nxt;
  logic [fsp_pkg::CODE_W-1:0]  outcome_r, outcome_nxt;

  fsp_pkg::state_t             state_r, state_nxt;

  logic                        in_accept;
  logic                        load;
  logic                        push;
  logic [fsp_pkg::BYTES_W-1:0] eff_bytes;
  logic [fsp_pkg::CNT_W-1:0]   eff_count;
  logic [fsp_pkg::CNT_W-1:0]   fresh_dec;
  logic [PROD_W-1:0]           fresh_offs;
  logic [PROD_W-1:0]           span;
  logic [fsp_pkg::ADDR_W-1:0]  offset;
  logic                        addr_hit;
  logic [fsp_pkg::ADDR_W-1:0]  top_data;
  logic                        cfg_hit;

  assign eff_bytes  = (slot_bytes_r < fsp_pkg::MIN_SLOT_BYTES) ?
                      fsp_pkg::MIN_SLOT_BYTES : slot_bytes_r;
  assign eff_count  = (slot_count_r > CAP_V) ? CAP_V : slot_count_r;
  assign fresh_dec  = fresh_left_r - fsp_pkg::CNT_W'(1);
  assign fresh_offs = fresh_dec * eff_bytes;
  assign span       = eff_count * eff_bytes;
  assign offset     = addr_r - pool_base_r;
  assign addr_hit   = ({(fsp_pkg::ADDR_W - PROD_W)'(0), span} > offset);

  assign in_accept = in_valid && !in_stall;
  assign cfg_hit   = cfg_we && ((cfg_index == fsp_pkg::REG_POOL_BASE) ||
                                (cfg_index == fsp_pkg::REG_SLOT_BYTES) ||
                                (cfg_index == fsp_pkg::REG_SLOT_COUNT));

  // The read port always points at the stack top, so the entry is ready in
  // the execute cycle. A push lands before the next beat's read.
  fsp_ram #(
    .WIDTH (fsp_pkg::ADDR_W),
    .DEPTH (POOL_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .we      (push),
    .wr_addr (stack_fill_r[AW-1:0]),
    .wr_data (addr_r),
    .rd_addr (AW'(stack_fill_r - FILL_W'(1))),
    .rd_data (top_data)
  );

  always_comb begin
    state_nxt      = state_r;
    in_stall       = 1'b1;
    load           = 1'b0;
    push           = 1'b0;
    fresh_left_nxt = fresh_left_r;
    stack_fill_nxt = stack_fill_r;
    addr_out_nxt   = addr_out_r;
    outcome_nxt    = outcome_r;
    out_valid_nxt  = out_valid_r && out_stall;
    case (state_r)
      fsp_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = fsp_pkg::S_EXEC;
        end
      end
      fsp_pkg::S_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = fsp_pkg::S_IDLE;
          addr_out_nxt  = '0;
          outcome_nxt   = fsp_pkg::OC_POOL;
          if (func_r == fsp_pkg::FUNC_ALLOC) begin
            if (req_r > eff_bytes) begin
              outcome_nxt = fsp_pkg::OC_HEAP;
            end else if (stack_fill_r != '0) begin
              stack_fill_nxt = stack_fill_r - FILL_W'(1);
              addr_out_nxt   = top_data;
            end else if (fresh_left_r != '0) begin
              fresh_left_nxt = fresh_dec;
              addr_out_nxt   = pool_base_r +
                               {(fsp_pkg::ADDR_W - PROD_W)'(0), fresh_offs};
            end else begin
              outcome_nxt = fsp_pkg::OC_HEAP;
            end
          end else begin
            if (addr_r == '0) begin
              outcome_nxt = fsp_pkg::OC_NULL;
            end else if (addr_hit) begin
              if (stack_fill_r != DEPTH_V) begin
                push           = 1'b1;
                stack_fill_nxt = stack_fill_r + FILL_W'(1);
              end else begin
                outcome_nxt = fsp_pkg::OC_OVERFLOW;
              end
            end else begin
              outcome_nxt = fsp_pkg::OC_HEAP;
            end
          end
        end
      end
      default: begin
        state_nxt = fsp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= fsp_pkg::RST_POOL_BASE;
      slot_bytes_r  <= fsp_pkg::RST_SLOT_BYTES;
      slot_count_r  <= fsp_pkg::RST_SLOT_COUNT;
      fresh_left_r  <= RST_EFF_COUNT;
      stack_fill_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_hit) begin
        case (cfg_index)
          fsp_pkg::REG_POOL_BASE: begin
            pool_base_r <= cfg_data;
          end
          fsp_pkg::REG_SLOT_BYTES: begin
            slot_bytes_r <= cfg_data[fsp_pkg::BYTES_W-1:0];
          end
          fsp_pkg::REG_SLOT_COUNT: begin
            slot_count_r <= cfg_data[fsp_pkg::CNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      // A configuration write re-initialises the pool from the new counts.
      if (cfg_hit) begin
        fresh_left_r <= (cfg_index == fsp_pkg::REG_SLOT_COUNT) ?
                        ((cfg_data[fsp_pkg::CNT_W-1:0] > CAP_V) ?
                         CAP_V : cfg_data[fsp_pkg::CNT_W-1:0]) : eff_count;
        stack_fill_r <= '0;
      end else begin
        fresh_left_r <= fresh_left_nxt;
        stack_fill_r <= stack_fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r <= in_func;
      req_r  <= in_req_bytes;
      addr_r <= in_addr_in;
    end
    addr_out_r <= addr_out_nxt;
    outcome_r  <= outcome_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_addr_out = addr_out_r;
  assign out_outcome  = outcome_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_fill_r <= DEPTH_V)
    else $error("stack fill beyond pool depth");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_left_r <= eff_count)
    else $error("fresh slot count beyond slot count");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == fsp_pkg::S_EXEC))
    else $error("accepted beat did not reach execute");

  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !cfg_we) |=> (stack_fill_r == $past(stack_fill_r) + FILL_W'(1)))
    else $error("pooled free did not grow the stack");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("execute did not present a result");

endmodule
